### hdl/cpid_pkg.sv
// ----------------------------------------------------------------------------
// cpid_pkg
// Types, widths and constants shared by the cooling PID controller modules.
// ----------------------------------------------------------------------------
package cpid_pkg;

  // field widths
  localparam int TEMP_W  = 16;
  localparam int TIME_W  = 32;
  localparam int GAIN_W  = 16;
  localparam int DRIVE_W = 8;

  // internal value widths
  localparam int ERR_W   = 17;  // measured - target
  localparam int DERR_W  = 18;  // error - previous error
  localparam int INTEG_W = 22;  // integral, 1/16 degC * ms, within +-1600000
  localparam int RATE_W  = 28;  // derivative, 1/16 degC per s
  localparam int ACC_W   = 56;  // weighted sum

  // shared multiplier
  localparam int MUL_AW = 33;
  localparam int MUL_BW = 28;
  localparam int MUL_PW = MUL_AW + MUL_BW;

  // divider, unsigned magnitudes
  localparam int DIV_NW = 28;
  localparam int DIV_DW = 32;
  localparam int DIV_CW = $clog2(DIV_NW);

  // configuration
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P = 2'd0,
    REG_GAIN_I = 2'd1,
    REG_GAIN_D = 2'd2,
    REG_TARGET = 2'd3
  } cfg_reg_e;

  localparam logic signed [GAIN_W-1:0] GAIN_P_RST = 16'sd256;
  localparam logic signed [GAIN_W-1:0] GAIN_I_RST = 16'sd0;
  localparam logic signed [GAIN_W-1:0] GAIN_D_RST = 16'sd0;
  localparam logic signed [TEMP_W-1:0] TARGET_RST = 16'sd480;

  // arithmetic constants
  localparam int INTEG_LIMIT = 1600000;     // 100 degC*s
  localparam int MS_PER_S    = 1000;
  localparam int DECAY_MUL   = 9;
  localparam int DECAY_DIV   = 10;
  localparam int SCALE_SHIFT = 12;          // 4096000 = 4096 * 1000
  localparam int DRIVE_CAP   = 1048576000;  // 256 * 4096000
  localparam int DRIVE_MAX   = 255;

  // reciprocals: exact floor divide for magnitudes below 2^24 (by 10)
  // and below 256000 (by 1000)
  localparam int DECAY_RECIP       = 13421773;  // ceil(2^27 / 10)
  localparam int DECAY_SHIFT       = 27;
  localparam int SCALE_RECIP       = 268436;    // ceil(2^28 / 1000)
  localparam int SCALE_RECIP_SHIFT = 28;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quot;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL_I,
    ST_INT,
    ST_DECAY,
    ST_MUL_D,
    ST_RATE_DIV,
    ST_RATE_WAIT,
    ST_KP,
    ST_PE,
    ST_KD,
    ST_DR,
    ST_KI,
    ST_SUM,
    ST_SCALE,
    ST_OUT_DIV
  } cpid_state_e;

endpackage

### hdl/cpid_div.sv
// ----------------------------------------------------------------------------
// cpid_div
// Restoring divider: one quotient bit per cycle, unsigned magnitudes.
// ----------------------------------------------------------------------------
module cpid_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cpid_pkg::div_req_t req_i,
  output cpid_pkg::div_rsp_t rsp_o
);
  import cpid_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DIV_CW-1:0] cnt_q, cnt_d;
  logic [DIV_DW:0]   rem_q, rem_d;
  logic [DIV_NW-1:0] quo_q, quo_d;
  logic [DIV_DW-1:0] den_q, den_d;
  logic [DIV_DW:0]   rem_sh;
  logic [DIV_DW:0]   trial;

  always_comb begin
    rem_sh = {rem_q[DIV_DW-1:0], quo_q[DIV_NW-1]};
    trial  = rem_sh - {1'b0, den_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = req_i.num;
      den_d  = req_i.den;
    end else if (busy_q) begin
      // borrow set: divisor does not fit, keep the shifted remainder
      if (trial[DIV_DW]) begin
        rem_d = rem_sh;
        quo_d = {quo_q[DIV_NW-2:0], 1'b0};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[DIV_NW-2:0], 1'b1};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CW'(DIV_NW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

endmodule

### hdl/cpid_mul.sv
// ----------------------------------------------------------------------------
// cpid_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module cpid_mul (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [cpid_pkg::MUL_AW-1:0]  a_i,
  input  logic signed [cpid_pkg::MUL_BW-1:0]  b_i,
  output logic signed [cpid_pkg::MUL_PW-1:0]  prod_o
);
  import cpid_pkg::*;

  logic signed [MUL_PW-1:0] prod_q;
  logic signed [MUL_PW-1:0] prod_d;

  assign prod_d = a_i * b_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

### hdl/cooling_pid_controller_top.sv
// ----------------------------------------------------------------------------
// cooling_pid_controller_top
// Cooling PID: error, integral, derivative and weighted drive sum, computed
// step by step on one shared multiplier and one divider.
// ----------------------------------------------------------------------------
// Sequence: a clear or a zero time step goes from PREP straight to OUT_DIV.
// A sample runs MUL_I, INT, DECAY when the integral decays, MUL_D, the rate
// divide on the 28-step divider, then KP, PE, KD, DR, KI, SUM, SCALE, OUT_DIV.
// One word at a time: s_axis_tready is high only when idle, so the next word
// can be taken at the earliest in the cycle in which the result is first presented.
// Reset: gains and setpoint return to defaults, controller state to zero.
// ----------------------------------------------------------------------------
module cooling_pid_controller_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // config write port
  input  logic                              cfg_we_i,
  input  logic [cpid_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [cpid_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [47:0]                       s_axis_tdata,  // measured_temperature, timestamp_ms
  input  logic [0:0]                        s_axis_tuser,  // action
  // output stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [cpid_pkg::DRIVE_W-1:0]      m_axis_tdata   // drive_level
);
  import cpid_pkg::*;

  cpid_state_e state_q, state_d;

  // configuration
  logic signed [GAIN_W-1:0] kp_q, ki_q, kd_q;
  logic signed [TEMP_W-1:0] target_q;

  // controller state
  logic signed [ERR_W-1:0]   prev_err_q, prev_err_d;
  logic signed [INTEG_W-1:0] integ_q, integ_d;
  logic [TIME_W-1:0]         prev_time_q, prev_time_d;

  // per-word working registers
  logic                      act_q;
  logic signed [TEMP_W-1:0]  temp_q;
  logic [TIME_W-1:0]         now_q;
  logic [TIME_W-1:0]         dt_q, dt_d;
  logic signed [ERR_W-1:0]   e_q, e_d;
  logic signed [DERR_W-1:0]  de_q, de_d;
  logic signed [RATE_W-1:0]  rate_q, rate_d;
  logic signed [ACC_W-1:0]   acc_q, acc_d;
  logic [DRIVE_W-1:0]        drive_q, drive_d;
  logic                      scale_pend_q, scale_pend_d;

  // output register
  logic                      out_valid_q, out_valid_d;
  logic [DRIVE_W-1:0]        out_data_q, out_data_d;

  // shared units
  logic                      mul_en;
  logic signed [MUL_AW-1:0]  mul_a;
  logic signed [MUL_BW-1:0]  mul_b;
  logic signed [MUL_PW-1:0]  prod;
  div_req_t                  div_req;
  div_rsp_t                  div_rsp;

  logic                      in_acc;
  logic [TIME_W-1:0]         dt_calc;
  logic signed [ERR_W-1:0]   e_calc;
  logic                      e_pos;
  logic [MUL_PW-1:0]         prod_abs;
  logic signed [MUL_PW:0]    isum;
  logic signed [DIV_NW:0]    quot_s;
  logic signed [DIV_NW:0]    quot_n;
  logic signed [DIV_NW:0]    quot_sel;

  cpid_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  cpid_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign dt_calc  = now_q - prev_time_q;
  assign e_calc   = ERR_W'(temp_q) - ERR_W'(target_q);
  assign e_pos    = !e_q[ERR_W-1] && (e_q != '0);
  assign prod_abs = prod[MUL_PW-1] ? MUL_PW'(-prod) : MUL_PW'(prod);
  assign isum     = (MUL_PW+1)'(integ_q) + (MUL_PW+1)'(prod);
  // divider magnitude back to a signed value, sign taken from the product
  assign quot_s   = $signed({1'b0, div_rsp.quot});
  assign quot_n   = -quot_s;
  assign quot_sel = prod[MUL_PW-1] ? quot_n : quot_s;

  always_comb begin
    state_d      = state_q;
    prev_err_d   = prev_err_q;
    integ_d      = integ_q;
    prev_time_d  = prev_time_q;
    dt_d         = dt_q;
    e_d          = e_q;
    de_d         = de_q;
    rate_d       = rate_q;
    acc_d        = acc_q;
    drive_d      = drive_q;
    scale_pend_d = scale_pend_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_data_d   = out_data_q;
    mul_en       = 1'b0;
    mul_a        = '0;
    mul_b        = '0;
    div_req      = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        prev_time_d  = now_q;
        dt_d         = dt_calc;
        e_d          = e_calc;
        de_d         = DERR_W'(e_calc) - DERR_W'(prev_err_q);
        drive_d      = '0;
        scale_pend_d = 1'b0;
        if (act_q) begin
          prev_err_d = '0;
          integ_d    = '0;
          state_d    = ST_OUT_DIV;
        end else if (dt_calc == '0) begin
          state_d = ST_OUT_DIV;
        end else begin
          state_d = ST_MUL_I;
        end
      end
      ST_MUL_I: begin
        mul_en = 1'b1;
        if (e_pos) begin
          mul_a = $signed({1'b0, dt_q});
          mul_b = MUL_BW'(e_q);
        end else begin
          mul_a = MUL_AW'(integ_q);
          mul_b = MUL_BW'(DECAY_MUL);
        end
        state_d = ST_INT;
      end
      ST_INT: begin
        if (e_pos) begin
          if (isum > (MUL_PW+1)'(INTEG_LIMIT)) begin
            integ_d = INTEG_W'(INTEG_LIMIT);
          end else if (isum < -(MUL_PW+1)'(INTEG_LIMIT)) begin
            integ_d = -INTEG_W'(INTEG_LIMIT);
          end else begin
            integ_d = INTEG_W'(isum);
          end
          state_d = ST_MUL_D;
        end else begin
          // |9 * I| / 10 by reciprocal multiply
          mul_en  = 1'b1;
          mul_a   = $signed({1'b0, prod_abs[MUL_AW-2:0]});
          mul_b   = MUL_BW'(DECAY_RECIP);
          state_d = ST_DECAY;
        end
      end
      ST_DECAY: begin
        // sign of 9 * I is the sign of I
        if (integ_q[INTEG_W-1]) begin
          integ_d = -$signed(prod[DECAY_SHIFT +: INTEG_W]);
        end else begin
          integ_d = $signed(prod[DECAY_SHIFT +: INTEG_W]);
        end
        state_d = ST_MUL_D;
      end
      ST_MUL_D: begin
        mul_en  = 1'b1;
        mul_a   = MUL_AW'(de_q);
        mul_b   = MUL_BW'(MS_PER_S);
        state_d = ST_RATE_DIV;
      end
      ST_RATE_DIV: begin
        div_req.start = 1'b1;
        div_req.num   = prod_abs[DIV_NW-1:0];
        div_req.den   = dt_q;
        state_d       = ST_RATE_WAIT;
      end
      ST_RATE_WAIT: begin
        if (div_rsp.done) begin
          rate_d     = RATE_W'(quot_sel);
          prev_err_d = e_q;
          state_d    = ST_KP;
        end
      end
      ST_KP: begin
        mul_en  = 1'b1;
        mul_a   = MUL_AW'(kp_q);
        mul_b   = MUL_BW'(MS_PER_S);
        state_d = ST_PE;
      end
      ST_PE: begin
        mul_en  = 1'b1;
        mul_a   = prod[MUL_AW-1:0];
        mul_b   = MUL_BW'(e_q);
        state_d = ST_KD;
      end
      ST_KD: begin
        acc_d   = ACC_W'(prod);
        mul_en  = 1'b1;
        mul_a   = MUL_AW'(kd_q);
        mul_b   = MUL_BW'(MS_PER_S);
        state_d = ST_DR;
      end
      ST_DR: begin
        mul_en  = 1'b1;
        mul_a   = prod[MUL_AW-1:0];
        mul_b   = rate_q;
        state_d = ST_KI;
      end
      ST_KI: begin
        acc_d   = acc_q + ACC_W'(prod);
        mul_en  = 1'b1;
        mul_a   = MUL_AW'(ki_q);
        mul_b   = MUL_BW'(integ_q);
        state_d = ST_SUM;
      end
      ST_SUM: begin
        acc_d   = acc_q + ACC_W'(prod);
        state_d = ST_SCALE;
      end
      ST_SCALE: begin
        if (acc_q[ACC_W-1] || acc_q == '0) begin
          drive_d = '0;
          state_d = ST_OUT_DIV;
        end else if (acc_q >= ACC_W'(DRIVE_CAP)) begin
          drive_d = DRIVE_W'(DRIVE_MAX);
          state_d = ST_OUT_DIV;
        end else begin
          // below the cap, acc >> 12 stays under 256000; / 1000 by reciprocal
          mul_en       = 1'b1;
          mul_a        = $signed({1'b0, acc_q[SCALE_SHIFT +: MUL_AW-1]});
          mul_b        = MUL_BW'(SCALE_RECIP);
          scale_pend_d = 1'b1;
          state_d      = ST_OUT_DIV;
        end
      end
      ST_OUT_DIV: begin
        // product is held here, so an in-range drive can wait for the output
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = scale_pend_q ? prod[SCALE_RECIP_SHIFT +: DRIVE_W] : drive_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      kp_q        <= GAIN_P_RST;
      ki_q        <= GAIN_I_RST;
      kd_q        <= GAIN_D_RST;
      target_q    <= TARGET_RST;
      prev_err_q  <= '0;
      integ_q     <= '0;
      prev_time_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      prev_err_q  <= prev_err_d;
      integ_q     <= integ_d;
      prev_time_q <= prev_time_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          REG_GAIN_P: kp_q     <= $signed(cfg_data_i);
          REG_GAIN_I: ki_q     <= $signed(cfg_data_i);
          REG_GAIN_D: kd_q     <= $signed(cfg_data_i);
          REG_TARGET: target_q <= $signed(cfg_data_i);
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q  <= s_axis_tuser[0];
      temp_q <= $signed(s_axis_tdata[TEMP_W-1:0]);
      now_q  <= s_axis_tdata[TEMP_W +: TIME_W];
    end
    dt_q         <= dt_d;
    e_q          <= e_d;
    de_q         <= de_d;
    rate_q       <= rate_d;
    acc_q        <= acc_d;
    drive_q      <= drive_d;
    scale_pend_q <= scale_pend_d;
    out_data_q   <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

### tb/tb_cooling_pid_controller_top.sv
// ----------------------------------------------------------------------------
// tb_cooling_pid_controller_top
// Drives action/temperature/timestamp words into the cooling PID and checks
// every drive level against a cycle-free predictor kept in the bench. Covers
// clears, zero and wrapped time steps, decay, integral saturation, full-range
// gains and setpoint, random idling on both streams and a long output stall.
// ----------------------------------------------------------------------------
module tb_cooling_pid_controller_top;
  import cpid_pkg::*;

  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_CLEAR  = 1'b1;

  localparam int GAINS_MODERATE     = 0;
  localparam int GAINS_FULL_RANDOM  = 1;
  localparam int GAINS_EXTREME_HIGH = 2;
  localparam int GAINS_EXTREME_LOW  = 3;

  localparam longint DRIVE_SCALE    = 4096000;
  localparam int     WATCHDOG_LIMIT = 3000;
  localparam int     STALL_HOLD     = 400;

  typedef struct packed {
    logic                     action;
    logic signed [TEMP_W-1:0] temp;
    logic [TIME_W-1:0]        ts;
  } pid_word_t;

  typedef struct packed {
    pid_word_t          word;
    logic [DRIVE_W-1:0] drive;
  } drive_expect_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [47:0]           s_axis_tdata;  // measured_temperature, timestamp_ms
  logic [0:0]            s_axis_tuser;  // action
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [DRIVE_W-1:0]    m_axis_tdata;  // drive_level

  cooling_pid_controller_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // bench copy of registers and controller state
  logic signed [GAIN_W-1:0] cfg_kp     = GAIN_P_RST;
  logic signed [GAIN_W-1:0] cfg_ki     = GAIN_I_RST;
  logic signed [GAIN_W-1:0] cfg_kd     = GAIN_D_RST;
  logic signed [TEMP_W-1:0] cfg_target = TARGET_RST;
  longint                   pid_prev_err = 0;
  longint                   pid_integral = 0;
  logic [TIME_W-1:0]        pid_prev_ts  = '0;

  drive_expect_t drive_expect_q[$];
  drive_expect_t head;

  logic [TIME_W-1:0] last_ts = '0;
  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int hold_left       = 0;
  int stall_cycles    = 0;
  int mismatches      = 0;
  int n_words = 0, n_clear = 0, n_hold = 0, n_decay = 0, n_sat = 0;
  int n_full = 0, n_mid = 0, n_settings = 0;

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  function automatic logic [DRIVE_W-1:0] predict_drive_level(input pid_word_t w);
    logic [TIME_W-1:0] dt;
    longint step, err, rate, acc, q;
    if (w.action == ACT_CLEAR) begin
      pid_prev_err = 0;
      pid_integral = 0;
      pid_prev_ts  = w.ts;
      n_clear++;
      return '0;
    end
    dt = w.ts - pid_prev_ts;
    pid_prev_ts = w.ts;
    if (dt == 0) begin
      n_hold++;
      return '0;
    end
    step = {32'd0, dt};
    err  = longint'(w.temp) - longint'(cfg_target);
    if (err > 0) begin
      pid_integral = pid_integral + err * step;
    end else begin
      pid_integral = (pid_integral * DECAY_MUL) / DECAY_DIV;
      n_decay++;
    end
    if (pid_integral > INTEG_LIMIT) begin
      pid_integral = INTEG_LIMIT;
      n_sat++;
    end else if (pid_integral < -INTEG_LIMIT) begin
      pid_integral = -INTEG_LIMIT;
      n_sat++;
    end
    // derivative in 1/16 degC per second, truncated toward zero
    rate = ((err - pid_prev_err) * MS_PER_S) / step;
    pid_prev_err = err;
    acc = MS_PER_S * (longint'(cfg_kp) * err + longint'(cfg_kd) * rate)
          + longint'(cfg_ki) * pid_integral;
    if (acc <= 0) return '0;
    q = acc / DRIVE_SCALE;
    if (q >= DRIVE_MAX) begin
      n_full++;
      return DRIVE_MAX[DRIVE_W-1:0];
    end
    n_mid++;
    return q[DRIVE_W-1:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [DRIVE_W-1:0] exp_v,
                                 input logic [DRIVE_W-1:0] got_v, input pid_word_t w);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch (%s): drive exp %0d got %0d  [action %0b temp %0d ts 0x%08h]",
               what, exp_v, got_v, w.action, w.temp, w.ts);
  endtask

  // output checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (drive_expect_q.size() == 0) begin
        report_mismatch("unexpected word", '0, m_axis_tdata, '0);
      end else begin
        head = drive_expect_q.pop_front();
        if (m_axis_tdata !== head.drive)
          report_mismatch("drive_level", head.drive, m_axis_tdata, head.word);
      end
    end
  end

  // receiver: random stalls, plus a counted hold-off when requested
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cycles = 0;
    else
      stall_cycles = stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no word accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("tb_cooling_pid_controller_top NOT OK");
      $finish;
    end
  end

  // returns at the accepting edge with tvalid still high
  task automatic send_item(input logic act, input logic signed [TEMP_W-1:0] temp,
                           input logic [TIME_W-1:0] ts);
    pid_word_t     w;
    drive_expect_t e;
    w = '{action: act, temp: temp, ts: ts};
    @(negedge clk_i);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {w.ts, w.temp};
    s_axis_tuser  <= w.action;
    do @(posedge clk_i); while (!s_axis_tready);
    e.word  = w;
    e.drive = predict_drive_level(w);
    drive_expect_q.push_back(e);
    last_ts = ts;
    n_words++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (drive_expect_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic signed [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      REG_GAIN_P: cfg_kp     = data;
      REG_GAIN_I: cfg_ki     = data;
      REG_GAIN_D: cfg_kd     = data;
      REG_TARGET: cfg_target = data;
      default: ;
    endcase
  endtask

  // only called with the block idle
  task automatic set_gains(input logic signed [15:0] kp, input logic signed [15:0] ki,
                           input logic signed [15:0] kd, input logic signed [15:0] tgt);
    write_reg(REG_GAIN_P, kp);
    write_reg(REG_GAIN_I, ki);
    write_reg(REG_GAIN_D, kd);
    write_reg(REG_TARGET, tgt);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  task automatic choose_gains(input int kind);
    case (kind)
      GAINS_MODERATE:
        set_gains(16'($urandom_range(3072) - 512), 16'($urandom_range(272) - 16),
                  16'($urandom_range(5120) - 1024), 16'($urandom_range(1600)));
      GAINS_FULL_RANDOM:
        set_gains(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()));
      GAINS_EXTREME_HIGH:
        set_gains(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
      default:
        set_gains(-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000);
    endcase
  endtask

  // mostly plausible samples near the setpoint, some noise and wraps
  task automatic run_random(input int count);
    int r, offs;
    logic              act;
    logic [TIME_W-1:0] dt;
    for (int i = 0; i < count; i++) begin
      act = ($urandom_range(99) < 4) ? ACT_CLEAR : ACT_SAMPLE;
      r = $urandom_range(99);
      if (r < 60)      offs = $urandom_range(1600) - 800;
      else if (r < 80) offs = $urandom_range(128) - 64;
      else             offs = $urandom();
      r = $urandom_range(99);
      if (r < 8)       dt = '0;
      else if (r < 60) dt = $urandom_range(200, 1);
      else if (r < 90) dt = $urandom_range(5000, 1);
      else if (r < 95) dt = $urandom_range(100000, 1);
      else             dt = $urandom();
      send_item(act, 16'(int'(cfg_target) + offs), last_ts + dt);
    end
  endtask

  task automatic test_directed_defaults();
    // first sample at time zero: zero step
    send_item(ACT_SAMPLE, 16'sd1280, 32'd0);
    send_item(ACT_SAMPLE, 16'sd1280, 32'd1000);
    send_item(ACT_SAMPLE, 16'sh7fff, 32'd2000);   // integral saturates, drive capped
    send_item(ACT_SAMPLE, -16'sh8000, 32'd3000);  // negative error, decay
    send_item(ACT_SAMPLE, 16'sd400, 32'd3001);
    send_item(ACT_CLEAR, 16'sh5a5a, 32'hffff_ff00);
    send_item(ACT_SAMPLE, 16'sd640, 32'h0000_0010);  // wrapped step
    send_item(ACT_SAMPLE, 16'sd480, 32'h0000_000f);  // step of 2^32 - 1
    send_item(ACT_SAMPLE, 16'sd700, 32'h0000_000f);  // zero step
    send_item(ACT_CLEAR, -16'sd1, 32'hffff_ffff);
    wait_drained();
    set_gains(16'sd512, 16'sd64, 16'sd1024, 16'sd480);
    send_item(ACT_SAMPLE, 16'sd800, 32'd500);
    send_item(ACT_SAMPLE, 16'sd960, 32'd750);
    send_item(ACT_SAMPLE, 16'sd560, 32'd760);     // falling error, negative rate
    wait_drained();
  endtask

  task automatic test_directed_extremes();
    set_gains(16'sh7fff, -16'sh8000, -16'sh8000, -16'sh8000);
    send_item(ACT_SAMPLE, 16'sh7fff, last_ts + 1);   // largest error
    send_item(ACT_SAMPLE, -16'sh8000, last_ts + 1);  // error zero, big fall
    send_item(ACT_SAMPLE, 16'sd0, last_ts + 32'd40000);
    wait_drained();
    set_gains(-16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_item(ACT_SAMPLE, -16'sh8000, last_ts + 1);  // most negative error
    send_item(ACT_SAMPLE, 16'sh7fff, last_ts + 1);   // steep rise
    send_item(ACT_SAMPLE, 16'sh7fff, last_ts + 32'h8000_0000);
    send_item(ACT_CLEAR, 16'sh7fff, last_ts);
    wait_drained();
  endtask

  task automatic test_random_phases();
    int idle_pct[4];
    int stall_pct[4];
    int second_kind[4];
    idle_pct    = '{0, 73, 0, 37};
    stall_pct   = '{0, 0, 73, 37};
    second_kind = '{GAINS_EXTREME_HIGH, GAINS_FULL_RANDOM, GAINS_EXTREME_LOW,
                    GAINS_MODERATE};
    for (int p = 0; p < 4; p++) begin
      sender_idle_pct = idle_pct[p];
      recv_stall_pct  = stall_pct[p];
      choose_gains(GAINS_MODERATE);
      run_random(100);
      wait_drained();
      choose_gains(second_kind[p]);
      run_random(80);
      wait_drained();
    end
  endtask

  task automatic test_backpressure();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    choose_gains(GAINS_MODERATE);
    hold_left = STALL_HOLD;  // output held off while the sender keeps offering
    run_random(30);
    wait_drained();
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_defaults();
    test_directed_extremes();
    test_random_phases();
    test_backpressure();

    wait_drained();
    repeat (120) @(posedge clk_i);
    if (drive_expect_q.size() != 0) begin
      $display("%0d expected words never arrived", drive_expect_q.size());
      mismatches += drive_expect_q.size();
    end

    $display("run: %0d words over %0d gain settings; %0d clears, %0d zero steps, %0d decays",
             n_words, n_settings, n_clear, n_hold, n_decay);
    $display("     %0d integral clamps, %0d drives at full scale, %0d in range, %0d mismatches",
             n_sat, n_full, n_mid, mismatches);
    if (mismatches == 0)
      $display("tb_cooling_pid_controller_top OK");
    else
      $display("tb_cooling_pid_controller_top NOT OK");
    $finish;
  end

endmodule
